FILE: rtl/core/pif_pkg.sv
// Shared types, constants and byte functions for the PNG IDAT chunk framer.
package pif_pkg;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_TOTAL_LENGTH = 1'b0,
		REG_MAX_CHUNK    = 1'b1
	} reg_idx_t;

	localparam int unsigned CFG_W     = 32;
	localparam int unsigned LEN_W     = 31;
	localparam int unsigned IDX_W     = 4;

	localparam logic [LEN_W-1:0] MAX_CHUNK_RESET = 31'd8192;
	localparam logic [31:0]      CRC_INIT        = 32'hFFFF_FFFF;
	localparam logic [31:0]      CRC_POLY        = 32'hEDB8_8320;

	localparam logic [IDX_W-1:0] HDR_LAST_IDX  = 4'd7;
	localparam logic [IDX_W-1:0] CRC_LAST_IDX  = 4'd3;
	localparam logic [IDX_W-1:0] IEND_LAST_IDX = 4'd11;

	// Work descriptor handed from the front to the back
	typedef struct packed {
		logic             hdr;      // open a chunk: length and tag first
		logic             data;     // carries a payload byte
		logic             crc;      // chunk closes after the payload byte
		logic             iend;     // stream closes: IEND trailer last
		logic [LEN_W-1:0] len;      // chunk length for the header
		logic [7:0]       payload;
	} desc_t;

	// Byte sequencer states
	typedef enum logic [3:0] {
		ST_HDR  = 4'b0001,
		ST_DATA = 4'b0010,
		ST_CRC  = 4'b0100,
		ST_IEND = 4'b1000
	} seq_state_t;

	// Reflected CRC-32, one byte folded in
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Big-endian byte pick, index 0 is the most significant byte
	function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0:    r = v[31:24];
			2'd1:    r = v[23:16];
			2'd2:    r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

	// "IDAT"
	function automatic logic [7:0] idat_tag_byte(input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0:    r = 8'd73;
			2'd1:    r = 8'd68;
			2'd2:    r = 8'd65;
			default: r = 8'd84;
		endcase
		return r;
	endfunction

	// Complete IEND chunk: zero length, tag, CRC
	function automatic logic [7:0] iend_byte(input logic [IDX_W-1:0] i);
		logic [7:0] r;
		case (i)
			4'd4:    r = 8'd73;
			4'd5:    r = 8'd69;
			4'd6:    r = 8'd78;
			4'd7:    r = 8'd68;
			4'd8:    r = 8'd174;
			4'd9:    r = 8'd66;
			4'd10:   r = 8'd96;
			4'd11:   r = 8'd130;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/pif_front.sv
// Front end: holds configuration, tracks stream and chunk counts, classifies each input byte.
module pif_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [pif_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       push,
	input  logic                       full,
	input  logic [7:0]                 data_byte,
	output logic                       q_wr,
	output pif_pkg::desc_t             q_desc
);

	logic [pif_pkg::LEN_W-1:0]  max_chunk_q;
	logic [31:0]                bytes_rem_q;
	logic [pif_pkg::LEN_W-1:0]  chunk_rem_q;
	logic                       finished_q;

	logic                       accept;
	logic                       has_data;
	logic                       open_chunk;
	logic [pif_pkg::LEN_W-1:0]  lim;
	logic [pif_pkg::LEN_W-1:0]  len;
	logic [pif_pkg::LEN_W-1:0]  chunk_next;
	logic [31:0]                bytes_next;

	assign accept = push && !full;

	// Classify the byte against the current counts
	always_comb begin
		has_data   = (bytes_rem_q != 32'd0);
		open_chunk = has_data && (chunk_rem_q == '0);
		lim        = (max_chunk_q == '0) ? {{(pif_pkg::LEN_W-1){1'b0}}, 1'b1} : max_chunk_q;
		len        = (bytes_rem_q < {1'b0, lim}) ? bytes_rem_q[pif_pkg::LEN_W-1:0] : lim;
		chunk_next = open_chunk ? (len - 1'b1)
		           : (has_data ? (chunk_rem_q - 1'b1) : chunk_rem_q);
		bytes_next = has_data ? (bytes_rem_q - 32'd1) : bytes_rem_q;

		q_desc.hdr     = open_chunk;
		q_desc.data    = has_data;
		q_desc.crc     = has_data && (chunk_next == '0);
		q_desc.iend    = (bytes_next == 32'd0);
		q_desc.len     = len;
		q_desc.payload = data_byte;
	end

	// Nothing is queued once the descriptor carrying the trailer was queued
	assign q_wr = accept && !finished_q;

	// Configuration and stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= pif_pkg::MAX_CHUNK_RESET;
			bytes_rem_q <= '0;
			chunk_rem_q <= '0;
			finished_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pif_pkg::REG_TOTAL_LENGTH: begin
					bytes_rem_q <= cfg_data;
					chunk_rem_q <= '0;
					finished_q  <= 1'b0;
				end
				pif_pkg::REG_MAX_CHUNK: begin
					max_chunk_q <= cfg_data[pif_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (q_wr) begin
			bytes_rem_q <= bytes_next;
			chunk_rem_q <= chunk_next;
			if (q_desc.iend) begin
				finished_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/pif_queue.sv
// Short descriptor queue between the front and the back.
module pif_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  pif_pkg::desc_t wr_desc,
	output logic           full,
	input  logic           rd,
	output pif_pkg::desc_t rd_desc,
	output logic           empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pif_pkg::desc_t   mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_desc = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule

FILE: rtl/core/pif_back.sv
// Back end: expands each descriptor into framed bytes, runs the chunk CRC, holds the output register.
module pif_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  pif_pkg::desc_t q_desc,
	output logic           q_rd,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     out_byte,
	output logic           last_of_run,
	output logic           stream_done
);

	pif_pkg::desc_t              cur_q;
	logic                        cur_valid_q;
	pif_pkg::seq_state_t         state_q;
	logic [pif_pkg::IDX_W-1:0]   idx_q;
	logic [31:0]                 crc_q;

	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        out_last_q;
	logic                        out_done_q;

	logic                        adv;
	logic                        load;
	logic [7:0]                  emit_byte;
	logic                        emit_last;
	logic                        emit_done;
	logic                        upd_crc;
	pif_pkg::seq_state_t         state_nx;
	logic [pif_pkg::IDX_W-1:0]   idx_nx;
	pif_pkg::seq_state_t         start_state;

	// Emit one byte whenever a descriptor is held and the output register is free or being drained
	assign adv  = cur_valid_q && (!out_valid_q || pop);
	assign load = !q_empty && (!cur_valid_q || (adv && emit_last));
	assign q_rd = load;

	assign start_state = q_desc.hdr  ? pif_pkg::ST_HDR
	                   : (q_desc.data ? pif_pkg::ST_DATA : pif_pkg::ST_IEND);

	// Byte sequencer
	always_comb begin
		emit_byte = '0;
		emit_last = 1'b0;
		emit_done = 1'b0;
		upd_crc   = 1'b0;
		state_nx  = state_q;
		idx_nx    = idx_q + 1'b1;
		unique case (state_q)
			pif_pkg::ST_HDR: begin
				upd_crc   = idx_q[2];
				emit_byte = idx_q[2] ? pif_pkg::idat_tag_byte(idx_q[1:0])
				                     : pif_pkg::be_byte({1'b0, cur_q.len}, idx_q[1:0]);
				if (idx_q == pif_pkg::HDR_LAST_IDX) begin
					state_nx = pif_pkg::ST_DATA;
					idx_nx   = '0;
				end
			end
			pif_pkg::ST_DATA: begin
				upd_crc   = 1'b1;
				emit_byte = cur_q.payload;
				idx_nx    = '0;
				if (cur_q.crc) begin
					state_nx = pif_pkg::ST_CRC;
				end else if (cur_q.iend) begin
					state_nx = pif_pkg::ST_IEND;
				end else begin
					emit_last = 1'b1;
				end
			end
			pif_pkg::ST_CRC: begin
				emit_byte = pif_pkg::be_byte(~crc_q, idx_q[1:0]);
				if (idx_q == pif_pkg::CRC_LAST_IDX) begin
					idx_nx = '0;
					if (cur_q.iend) begin
						state_nx = pif_pkg::ST_IEND;
					end else begin
						emit_last = 1'b1;
					end
				end
			end
			pif_pkg::ST_IEND: begin
				emit_byte = pif_pkg::iend_byte(idx_q);
				if (idx_q == pif_pkg::IEND_LAST_IDX) begin
					emit_last = 1'b1;
					emit_done = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			state_q     <= pif_pkg::ST_IEND;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				state_q     <= start_state;
				idx_q       <= '0;
			end else if (adv) begin
				cur_valid_q <= !emit_last;
				state_q     <= state_nx;
				idx_q       <= idx_nx;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Descriptor, CRC and output payload
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_desc;
		end
		if (load && q_desc.hdr) begin
			crc_q <= pif_pkg::CRC_INIT;
		end else if (adv && upd_crc) begin
			crc_q <= pif_pkg::crc_byte(crc_q, emit_byte);
		end
		if (adv) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
			out_done_q <= emit_done;
		end
	end

	assign empty       = !out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
	assign stream_done = out_done_q;

	// Trailer end always closes the run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_done_q |-> out_last_q)
		else $error("stream_done without last_of_run");

	// Header bytes only for descriptors that open a chunk
	a_hdr_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && (state_q == pif_pkg::ST_HDR) |-> cur_q.hdr)
		else $error("header sequence without chunk open");

	// CRC bytes only when the chunk closes
	a_crc_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && (state_q == pif_pkg::ST_CRC) |-> cur_q.crc)
		else $error("CRC sequence without chunk close");

	// Byte index stays inside the trailer
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (idx_q <= pif_pkg::IEND_LAST_IDX))
		else $error("byte index out of range");

	// A stalled result holds its byte
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_byte_q))
		else $error("result changed while stalled");

endmodule

FILE: rtl/core/png_idat_chunk_framer.sv
// Top level of the PNG IDAT chunk framer: front classifier, descriptor queue, byte sequencer.
// Usage: write total_length (this restarts the stream) and max_chunk_length while idle,
// then push compressed payload bytes; the result side delivers the framed byte stream
// (per-chunk 4-byte length, "IDAT", payload, big-endian CRC-32) followed by the IEND chunk.
// Input bytes are taken one per cycle as long as the descriptor queue has room. The byte
// sequencer in the back end emits at most one output byte per cycle, and only while the
// output register is free or being popped; an input byte yields its payload byte, plus 8
// header bytes when it opens a chunk, plus 4 CRC bytes when it closes one, plus 12 IEND
// bytes when it ends the stream (up to 25); a byte that meets an empty stream yields only
// the 12 IEND bytes. Header and trailer bursts are absorbed by the QUEUE_DEPTH-entry queue;
// longer bursts back-pressure through full. With a total length of zero the first pushed
// byte is dropped and yields only IEND; bytes pushed after IEND are accepted and dropped.
module png_idat_chunk_framer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [pif_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 data_byte,
	output logic                       empty,
	input  logic                       pop,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run,
	output logic                       stream_done
);

	logic           q_wr;
	logic           q_rd;
	logic           q_empty;
	pif_pkg::desc_t wr_desc;
	pif_pkg::desc_t rd_desc;

	pif_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.q_wr      (q_wr),
		.q_desc    (wr_desc)
	);

	pif_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_desc (wr_desc),
		.full    (full),
		.rd      (q_rd),
		.rd_desc (rd_desc),
		.empty   (q_empty)
	);

	pif_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_desc      (rd_desc),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.stream_done (stream_done)
	);

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the PNG IDAT chunk framer: directed cases, then random streams.
module tb_top;

	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned LONG_HOLD     = 300;

	localparam logic [31:0] IDAT_TAG   = {8'd73, 8'd68, 8'd65, 8'd84};
	localparam logic [95:0] IEND_CHUNK = {8'd0, 8'd0, 8'd0, 8'd0, 8'd73, 8'd69, 8'd78, 8'd68,
		8'd174, 8'd66, 8'd96, 8'd130};

	typedef struct packed {
		logic [7:0] ob;
		logic       last;
		logic       done;
	} frame_byte_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [0:0]                 cfg_index;
	logic [pif_pkg::CFG_W-1:0]  cfg_data;
	logic                       push;
	logic                       full;
	logic [7:0]                 data_byte;
	logic                       empty;
	logic                       pop;
	logic [7:0]                 out_byte;
	logic                       last_of_run;
	logic                       stream_done;

	png_idat_chunk_framer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.stream_done (stream_done)
	);

	// Framing state of the predictor
	logic [31:0]               total_len;
	logic [pif_pkg::LEN_W-1:0] chunk_lim;
	logic [31:0]               left_bytes;
	logic [pif_pkg::LEN_W-1:0] left_in_chunk;
	logic [31:0]               crc_acc;
	bit                        stream_closed;

	frame_byte_t framed_q[$];
	int unsigned errors;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned hold_req;
	int unsigned hold_left;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Reflected CRC-32, one byte at a time
	function automatic logic [31:0] fold_crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ pif_pkg::CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic void restart_stream();
		left_bytes    = total_len;
		left_in_chunk = '0;
		crc_acc       = pif_pkg::CRC_INIT;
		stream_closed = 1'b0;
	endfunction

	// Framed bytes caused by one payload byte, appended to the expected stream
	function automatic void frame_step(input logic [7:0] b);
		logic [7:0]                run[$];
		logic [pif_pkg::LEN_W-1:0] lim;
		logic [31:0]               len;
		logic [31:0]               crc_out;
		logic                      closes;
		frame_byte_t               fb;
		if (stream_closed)
			return;
		closes = 1'b0;
		if (left_bytes != 0) begin
			if (left_in_chunk == 0) begin
				lim = (chunk_lim == 0) ? 31'd1 : chunk_lim;
				len = (left_bytes < {1'b0, lim}) ? left_bytes : {1'b0, lim};
				for (int k = 0; k < 4; k++)
					run.push_back(len[31-8*k -: 8]);
				crc_acc = pif_pkg::CRC_INIT;
				for (int k = 0; k < 4; k++) begin
					run.push_back(IDAT_TAG[31-8*k -: 8]);
					crc_acc = fold_crc_byte(crc_acc, IDAT_TAG[31-8*k -: 8]);
				end
				left_in_chunk = len[pif_pkg::LEN_W-1:0];
			end
			run.push_back(b);
			crc_acc = fold_crc_byte(crc_acc, b);
			left_in_chunk = left_in_chunk - 1'b1;
			left_bytes = left_bytes - 1;
			// chunk closes: big-endian CRC trailer
			if (left_in_chunk == 0) begin
				crc_out = ~crc_acc;
				for (int k = 0; k < 4; k++)
					run.push_back(crc_out[31-8*k -: 8]);
				crc_acc = pif_pkg::CRC_INIT;
			end
		end
		if (left_bytes == 0) begin
			for (int k = 0; k < 12; k++)
				run.push_back(IEND_CHUNK[95-8*k -: 8]);
			stream_closed = 1'b1;
			closes = 1'b1;
		end
		for (int i = 0; i < run.size(); i++) begin
			fb.ob   = run[i];
			fb.last = (i == run.size() - 1);
			fb.done = closes && fb.last;
			framed_q.push_back(fb);
		end
	endfunction

	// Receiver: random stalls, or a long hold-off on request
	initial begin
		pop = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Compare each output transfer with the oldest expected byte
	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && pop && !empty) begin
			if (framed_q.size() == 0) begin
				$error("out_byte: no byte expected, got %0h", out_byte);
				errors++;
			end else begin
				want = framed_q.pop_front();
				if (out_byte !== want.ob) begin
					$error("out_byte: expected %0h, got %0h", want.ob, out_byte);
					errors++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
					errors++;
				end
				if (stream_done !== want.done) begin
					$error("stream_done: expected %0b, got %0b", want.done, stream_done);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	task automatic send_payload(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (full);
		frame_step(b);
	endtask

	task automatic stop_push();
		@(negedge clk);
		push <= 1'b0;
	endtask

	// Wait for every expected byte, then let dropped bytes drain out of the block
	task automatic settle_idle();
		stop_push();
		while (framed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input pif_pkg::reg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == pif_pkg::REG_TOTAL_LENGTH) begin
			total_len = v;
			restart_stream();
		end else begin
			chunk_lim = v[pif_pkg::LEN_W-1:0];
		end
	endtask

	task automatic setup_stream(input logic [31:0] total, input logic [31:0] lim);
		settle_idle();
		write_reg(pif_pkg::REG_MAX_CHUNK, lim);
		write_reg(pif_pkg::REG_TOTAL_LENGTH, total);
	endtask

	// Reset values: empty stream gives IEND only, later bytes are dropped
	task automatic test_reset_defaults();
		send_payload(8'h5A);
		send_payload(8'hFF);
		send_payload(8'h00);
	endtask

	// A zero limit acts as one byte per chunk
	task automatic test_zero_limit();
		setup_stream(32'd3, 32'd0);
		send_payload(8'h00);
		send_payload(8'hFF);
		send_payload(8'hA5);
		send_payload(8'h3C);
	endtask

	// Bit 31 of the limit write is outside the register
	task automatic test_masked_limit();
		setup_stream(32'd5, 32'h8000_0002);
		for (int i = 0; i < 5; i++)
			send_payload(8'h80 >> i);
	endtask

	// Largest total and limit; the open chunk is abandoned by the next stream
	task automatic test_largest_values();
		setup_stream(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_payload(8'h01);
		send_payload(8'hFE);
		send_payload(8'h7F);
	endtask

	// Limit rewritten inside a chunk applies from the next chunk
	task automatic test_limit_mid_chunk();
		setup_stream(32'd6, 32'd4);
		send_payload(8'h11);
		send_payload(8'h22);
		settle_idle();
		write_reg(pif_pkg::REG_MAX_CHUNK, 32'd1);
		send_payload(8'h33);
		send_payload(8'h44);
		send_payload(8'h55);
		send_payload(8'h66);
	endtask

	// Receiver holds off so the block fills; sender then waits for a full drain mid-stream
	task automatic test_backpressure();
		setup_stream(32'd40, 32'd1);
		idle_pct = 0;
		stall_pct = 0;
		hold_req = LONG_HOLD;
		for (int i = 0; i < 20; i++)
			send_payload(8'($urandom));
		stop_push();
		while (framed_q.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 20; i++)
			send_payload(8'($urandom));
	endtask

	// Random streams with mostly small limits; some cut short, some with trailing bytes
	task automatic run_random_phase(input int unsigned idle, input int unsigned stall,
		input int unsigned target);
		int unsigned count;
		int unsigned n;
		int unsigned sel;
		int unsigned sends;
		logic [31:0] lim;
		count = 0;
		idle_pct = idle;
		stall_pct = stall;
		while (count < target) begin
			sel = $urandom_range(9);
			if (sel < 6)
				lim = $urandom_range(8);
			else if (sel < 8)
				lim = $urandom_range(64, 9);
			else if (sel == 8)
				lim = $urandom;
			else
				lim = 32'h7FFF_FFFF;
			n = ($urandom_range(9) == 0) ? 0 : $urandom_range(48, 1);
			setup_stream(n, lim);
			if ($urandom_range(9) < 7)
				sends = ((n == 0) ? 1 : n) + $urandom_range(2);
			else
				sends = $urandom_range(n);
			for (int i = 0; i < sends; i++)
				send_payload(8'($urandom));
			count += (sends < n) ? sends : ((n == 0) ? 1 : n);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_index = pif_pkg::REG_TOTAL_LENGTH;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		errors = 0;
		quiet_cycles = 0;
		total_len = 32'd0;
		chunk_lim = pif_pkg::MAX_CHUNK_RESET;
		restart_stream();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_zero_limit();
		test_masked_limit();
		test_largest_values();
		test_limit_mid_chunk();
		test_backpressure();
		run_random_phase(0, 0, 100);
		run_random_phase(53, 0, 100);
		run_random_phase(0, 53, 100);
		run_random_phase(35, 35, 100);

		settle_idle();
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/pif_pkg.sv
rtl/core/pif_front.sv
rtl/core/pif_queue.sv
rtl/core/pif_back.sv
rtl/core/png_idat_chunk_framer.sv
sim/tb_top.sv
